/* hw/rtl/u16u8_pkg.sv */
// Shared types and helpers for the UTF-16 to UTF-8 converter.
// Used by the front, queue, back and top-level modules. No dependencies.
package u16u8_pkg;

  localparam logic [7:0]  BOM_HI     = 8'hfe;
  localparam logic [7:0]  BOM_LO     = 8'hff;
  localparam logic [5:0]  HIGH_SURR  = 6'b110110;
  localparam logic [5:0]  LOW_SURR   = 6'b110111;
  localparam logic [15:0] NONCHAR    = 16'hfffe;
  localparam logic [20:0] SUPP_BASE  = 21'h10000;
  localparam logic [15:0] CAP_MARGIN = 16'd5;
  localparam logic [7:0]  LEAD2      = 8'hc0;
  localparam logic [7:0]  LEAD3      = 8'he0;
  localparam logic [7:0]  LEAD4      = 8'hf0;
  localparam logic [7:0]  CONT       = 8'h80;
  localparam logic        ADDR_DEST_CAPACITY = 1'b0;
  localparam logic [15:0] DEST_CAPACITY_RESET = 16'd256;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       first_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;
  } out_item_t;

  // one classified input: a scalar to encode (len bytes) and an optional NUL
  typedef struct packed {
    logic [20:0] code;
    logic [2:0]  len;
    logic        nul;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [2:0] utf8_len(input logic [20:0] c);
    logic [2:0] n;
    if (c < 21'h80) begin
      n = 3'd1;
    end else if (c < 21'h800) begin
      n = 3'd2;
    end else if (c < 21'h10000) begin
      n = 3'd3;
    end else begin
      n = 3'd4;
    end
    return n;
  endfunction

endpackage

/* hw/rtl/utf16_to_utf8_converter.sv */
// UTF-16 to UTF-8 converter top level: APB register, front end, job queue, back end.
// A source byte's job is queued, then its bytes are registered in the result slot.
// Throughput: one input byte per cycle while the queue has room; one output byte
// per cycle while the result slot is empty or popped; a job gives 1 to 5 bytes.
// Reset (rst, synchronous): clears string state, queue and output slot;
// dest_capacity returns to 256.
module utf16_to_utf8_converter #(
  parameter int QDEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  u16u8_pkg::in_item_t  in_item,
  output logic                 empty,
  input  logic                 pop,
  output u16u8_pkg::out_item_t out_item,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import u16u8_pkg::*;

  logic [15:0] dest_capacity;
  logic        accept;
  job_t        f_job;
  logic        f_job_valid;
  job_t        q_head;
  q_stat_t     q_stat;
  logic        deq;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == ADDR_DEST_CAPACITY) ? {16'd0, dest_capacity} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      dest_capacity <= DEST_CAPACITY_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == ADDR_DEST_CAPACITY)) begin
      dest_capacity <= pwdata[15:0];
    end
  end

  assign full   = q_stat.full;
  assign accept = push && !full;

  u16u8_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .in_item       (in_item),
    .dest_capacity (dest_capacity),
    .job           (f_job),
    .job_valid     (f_job_valid)
  );

  u16u8_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (f_job_valid),
    .wr_job (f_job),
    .rd     (deq),
    .head   (q_head),
    .stat   (q_stat)
  );

  u16u8_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .head_valid (!q_stat.empty),
    .pop        (pop),
    .deq        (deq),
    .out_item   (out_item),
    .empty      (empty)
  );

`ifndef SYNTHESIS
  a_queue_stat: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  a_nul_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_item.string_end) |-> (out_item.run_last && out_item.out_byte == 8'd0))
    else $error("terminator is not the closing zero byte of its transaction");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("result slot or queue not cleared by reset");

  a_deq_needs_slot: assert property (@(posedge clk) disable iff (rst)
    deq |-> (!q_stat.empty && (empty || pop)))
    else $error("job retired without a free result slot");
`endif

endmodule

/* hw/rtl/u16u8_front.sv */
// Front end: byte-order header, unit assembly, surrogate pairing, capacity limit.
// Emits one job per accepted byte that causes output. Depends on u16u8_pkg.
module u16u8_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  u16u8_pkg::in_item_t in_item,
  input  logic [15:0]         dest_capacity,
  output u16u8_pkg::job_t     job,
  output logic                job_valid
);
  import u16u8_pkg::*;

  logic        big_endian, big_endian_next;
  logic [1:0]  header_count, header_count_next;
  logic [7:0]  held_byte, held_byte_next;
  logic        byte_phase, byte_phase_next;
  logic [9:0]  high_bits, high_bits_next;
  logic        high_pending, high_pending_next;
  logic        halted, halted_next;
  logic [15:0] bytes_written, bytes_written_next;

  logic        s_be, s_phase, s_hp, s_halted;
  logic [1:0]  s_hc;
  logic [7:0]  s_held;
  logic [9:0]  s_hb;
  logic [15:0] s_bw;
  logic [15:0] limit;
  logic [15:0] unit;
  logic [7:0]  b;

  always_comb begin
    b        = in_item.in_byte;
    s_be     = in_item.first_byte ? 1'b0  : big_endian;
    s_hc     = in_item.first_byte ? 2'd0  : header_count;
    s_held   = in_item.first_byte ? 8'd0  : held_byte;
    s_phase  = in_item.first_byte ? 1'b0  : byte_phase;
    s_hb     = in_item.first_byte ? 10'd0 : high_bits;
    s_hp     = in_item.first_byte ? 1'b0  : high_pending;
    s_halted = in_item.first_byte ? 1'b0  : halted;
    s_bw     = in_item.first_byte ? 16'd0 : bytes_written;
    limit    = (dest_capacity >= CAP_MARGIN) ? dest_capacity - CAP_MARGIN : 16'd0;
    unit     = s_be ? {s_held, b} : {b, s_held};

    big_endian_next   = s_be;
    header_count_next = s_hc;
    held_byte_next    = s_held;
    byte_phase_next   = s_phase;
    high_bits_next    = s_hb;
    high_pending_next = s_hp;
    halted_next       = s_halted;
    job.code          = 21'd0;
    job.len           = 3'd0;
    job.nul           = in_item.last_byte;

    if (s_hc == 2'd0) begin
      held_byte_next    = b;
      header_count_next = 2'd1;
    end else if (s_hc == 2'd1) begin
      big_endian_next   = (s_held == BOM_HI) && (b == BOM_LO);
      header_count_next = 2'd2;
    end else if (!s_phase) begin
      held_byte_next  = b;
      byte_phase_next = 1'b1;
    end else begin
      byte_phase_next = 1'b0;
      if (!s_halted) begin
        if (s_hp) begin
          high_pending_next = 1'b0;
          if (unit[15:10] == LOW_SURR) begin
            job.code = {1'b0, s_hb, unit[9:0]} + SUPP_BASE;
            job.len  = 3'd4;
          end else begin
            halted_next = 1'b1;
          end
        end else if (s_bw >= limit) begin
          halted_next = 1'b1;
        end else if (unit[15:10] == HIGH_SURR) begin
          high_bits_next    = unit[9:0];
          high_pending_next = 1'b1;
        end else if (unit < NONCHAR) begin
          job.code = {5'd0, unit};
          job.len  = utf8_len({5'd0, unit});
        end
      end
    end

    if (in_item.last_byte) begin
      if (high_pending_next && !halted_next) begin
        job.code = {5'd0, HIGH_SURR, high_bits_next};
        job.len  = 3'd3;
      end
      high_pending_next = 1'b0;
      byte_phase_next   = 1'b0;
      halted_next       = 1'b1;
    end

    bytes_written_next = s_bw + {13'd0, job.len};
    job_valid = accept && ((job.len != 3'd0) || job.nul);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      big_endian    <= 1'b0;
      header_count  <= 2'd0;
      held_byte     <= 8'd0;
      byte_phase    <= 1'b0;
      high_bits     <= 10'd0;
      high_pending  <= 1'b0;
      halted        <= 1'b0;
      bytes_written <= 16'd0;
    end else if (accept) begin
      big_endian    <= big_endian_next;
      header_count  <= header_count_next;
      held_byte     <= held_byte_next;
      byte_phase    <= byte_phase_next;
      high_bits     <= high_bits_next;
      high_pending  <= high_pending_next;
      halted        <= halted_next;
      bytes_written <= bytes_written_next;
    end
  end

endmodule

/* hw/rtl/u16u8_queue.sv */
// Job queue between the front and back ends.
// Register-based circular buffer of job_t entries. Depends on u16u8_pkg.
module u16u8_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr,
  input  u16u8_pkg::job_t    wr_job,
  input  logic               rd,
  output u16u8_pkg::job_t    head,
  output u16u8_pkg::q_stat_t stat
);
  import u16u8_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr, do_rd;

  assign stat.full  = (count == FULL_CNT);
  assign stat.empty = (count == '0);
  assign do_wr      = wr && !stat.full;
  assign do_rd      = rd && !stat.empty;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/u16u8_back.sv */
// Back end: serializes jobs to UTF-8 bytes plus optional NUL, one per cycle while
// the registered result slot it drives is empty or popped. Depends on u16u8_pkg.
module u16u8_back (
  input  logic                 clk,
  input  logic                 rst,
  input  u16u8_pkg::job_t      head,
  input  logic                 head_valid,
  input  logic                 pop,
  output logic                 deq,
  output u16u8_pkg::out_item_t out_item,
  output logic                 empty
);
  import u16u8_pkg::*;

  logic [2:0] idx;
  logic [2:0] total;
  logic [2:0] rem;
  logic       out_valid;
  logic       emit;
  out_item_t  nxt;

  always_comb begin
    total = head.len + {2'd0, head.nul};
    rem   = head.len - idx - 3'd1;
    emit  = head_valid && (!out_valid || pop);
    deq   = emit && (idx == total - 3'd1);

    nxt.run_last   = (idx == total - 3'd1);
    nxt.string_end = (idx >= head.len);
    if (idx >= head.len) begin
      nxt.out_byte = 8'd0;
    end else if (idx == 3'd0) begin
      case (head.len)
        3'd1:    nxt.out_byte = {1'b0, head.code[6:0]};
        3'd2:    nxt.out_byte = LEAD2 | {3'd0, head.code[10:6]};
        3'd3:    nxt.out_byte = LEAD3 | {4'd0, head.code[15:12]};
        default: nxt.out_byte = LEAD4 | {5'd0, head.code[20:18]};
      endcase
    end else begin
      case (rem)
        3'd0:    nxt.out_byte = CONT | {2'd0, head.code[5:0]};
        3'd1:    nxt.out_byte = CONT | {2'd0, head.code[11:6]};
        default: nxt.out_byte = CONT | {2'd0, head.code[17:12]};
      endcase
    end
  end

  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 3'd0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (deq) begin
        idx <= 3'd0;
      end else if (emit) begin
        idx <= idx + 3'd1;
      end
    end
  end

endmodule
